@@ rtl/ramc_pkg.sv @@
// ----------------------------------------------------------------------------
// ramc_pkg
// Shared constants and codes for the rational add / multiply / compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ramc_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    localparam int FIELD_W    = 16;
    localparam int REQ_W      = 2;
    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int RES_NUM_W  = 33;
    localparam int RES_DEN_W  = 32;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD = 2'd0,
        REQ_MUL = 2'd1,
        REQ_CMP = 2'd2,
        REQ_RSV = 2'd3
    } t_req;

endpackage

`default_nettype wire

@@ rtl/ramc_gcd.sv @@
// ----------------------------------------------------------------------------
// ramc_gcd
// Binary gcd, one shift or subtract per cycle; returns 1 if either input is 0.
// ----------------------------------------------------------------------------
`default_nettype none

module ramc_gcd #(
    parameter int N = 33
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [N-1:0] i_a,
    input  wire logic [N-1:0] i_b,
    output logic              o_done,
    output logic [N-1:0]      o_g
);

    localparam int KW = $clog2(N + 1);

    typedef enum logic [2:0] {
        G_IDLE  = 3'b001,
        G_RUN   = 3'b010,
        G_SHIFT = 3'b100
    } t_gst;

    t_gst           r_st;
    logic           r_done;
    logic [N-1:0]   r_a;
    logic [N-1:0]   r_b;
    logic [KW-1:0]  r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= G_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                G_IDLE: begin
                    if (i_start) begin
                        r_k <= '0;
                        if (i_a == '0 || i_b == '0) begin
                            r_a  <= N'(1);
                            r_st <= G_SHIFT;
                        end else begin
                            r_a  <= i_a;
                            r_b  <= i_b;
                            r_st <= G_RUN;
                        end
                    end
                end
                G_RUN: begin
                    if (r_a == r_b) begin
                        r_st <= G_SHIFT;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a > r_b) begin
                        r_a <= r_a - r_b;
                    end else begin
                        r_b <= r_b - r_a;
                    end
                end
                G_SHIFT: begin
                    if (r_k == '0) begin
                        r_done <= 1'b1;
                        r_st   <= G_IDLE;
                    end else begin
                        r_a <= r_a << 1;
                        r_k <= r_k - KW'(1);
                    end
                end
                default: begin
                    r_st <= G_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_g    = r_a;

endmodule

`default_nettype wire

@@ rtl/ramc_div.sv @@
// ----------------------------------------------------------------------------
// ramc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ramc_div #(
    parameter int N = 33
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [N-1:0] i_dividend,
    input  wire logic [N-1:0] i_divisor,
    output logic              o_done,
    output logic [N-1:0]      o_quot
);

    localparam int CW = $clog2(N + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_q;
    logic [N-1:0]  r_rem;
    logic [N-1:0]  r_d;
    logic [N:0]    w_trial;
    logic [N:0]    w_diff;

    assign w_trial = {r_rem, r_q[N-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_q    <= i_dividend;
                    r_d    <= i_divisor;
                    r_rem  <= '0;
                    r_cnt  <= CW'(N);
                    r_busy <= 1'b1;
                end
            end else begin
                if (!w_diff[N]) begin
                    r_rem <= w_diff[N-1:0];
                    r_q   <= {r_q[N-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[N-1:0];
                    r_q   <= {r_q[N-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

@@ rtl/ramc_mul.sv @@
// ----------------------------------------------------------------------------
// ramc_mul
// Shift-add multiplier, one multiplier bit per cycle, stops when bits run out.
// ----------------------------------------------------------------------------
`default_nettype none

module ramc_mul #(
    parameter int W = 16,
    parameter int N = 33
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_done,
    output logic [N-1:0]      o_prod
);

    logic         r_busy;
    logic         r_done;
    logic [N-1:0] r_a;
    logic [W-1:0] r_b;
    logic [N-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_a    <= N'(i_a);
                    r_b    <= i_b;
                    r_p    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_b == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                if (r_b[0]) begin
                    r_p <= r_p + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

`default_nettype wire

@@ rtl/rational_add_mul_compare.sv @@
// ----------------------------------------------------------------------------
// rational_add_mul_compare
// Normalizes two fractions, then adds, multiplies or compares them.
// ----------------------------------------------------------------------------
// Run time: set by the bit-serial gcd and the restoring divider (N = 2*W+1)
//   and, for add and multiply, the shift-add multiplier; an operand with a
//   zero denominator skips the gcd and divider, so compare of two empty
//   operands is the quickest case.
// Throughput: one beat in flight; a new beat is taken while the result waits.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_add_mul_compare #(
    parameter int OPERAND_WIDTH = ramc_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // left_num, left_den, right_num, right_den
    input  wire logic [ramc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type
    input  wire logic [ramc_pkg::REQ_W-1:0]      i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // res_num, res_den, res_empty, is_equal, not_equal, zero pad
    output logic [ramc_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    import ramc_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int N  = 2 * W + 1;
    localparam int IW = (W < FIELD_W) ? W : FIELD_W;
    localparam int PAD_W = OUT_DATA_W - RES_NUM_W - RES_DEN_W - 3;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_LOAD  = 11'b00000000010,
        S_GCD   = 11'b00000000100,
        S_DIVNS = 11'b00000001000,
        S_DIVN  = 11'b00000010000,
        S_DIVDS = 11'b00000100000,
        S_DIVD  = 11'b00001000000,
        S_NEXT  = 11'b00010000000,
        S_MULS  = 11'b00100000000,
        S_MUL   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    typedef enum logic [2:0] {
        PH_LEFT  = 3'b001,
        PH_RIGHT = 3'b010,
        PH_RES   = 3'b100
    } t_phase;

    t_state       r_st;
    t_phase       r_ph;
    t_req         r_op;
    logic [1:0]   r_mi;
    logic [N-1:0] r_x;
    logic [N-1:0] r_y;
    logic [N-1:0] r_g;
    logic [N-1:0] r_p0;
    logic [N-1:0] r_p1;
    logic [W-1:0] r_ln;
    logic [W-1:0] r_ld;
    logic [W-1:0] r_rn;
    logic [W-1:0] r_rd;

    logic                 r_ov;
    logic [RES_NUM_W-1:0] r_onum;
    logic [RES_DEN_W-1:0] r_oden;
    logic                 r_oemp;
    logic                 r_oeq;
    logic                 r_one;

    logic         w_gcd_done;
    logic [N-1:0] w_gcd;
    logic         w_div_done;
    logic [N-1:0] w_quot;
    logic         w_mul_done;
    logic [N-1:0] w_prod;
    logic [W-1:0] w_ma;
    logic [W-1:0] w_mb;
    logic         w_is_cmp;
    logic         w_same;
    logic         w_both;

    assign w_is_cmp = (r_op != REQ_ADD) && (r_op != REQ_MUL);
    assign w_same   = (r_ln == r_rn) && (r_ld == r_rd);
    assign w_both   = (r_ld == '0) && (r_rd == '0);

    always_comb begin
        w_ma = r_ld;
        w_mb = r_rd;
        case (r_mi)
            2'd0: begin
                w_ma = r_ln;
                w_mb = (r_op == REQ_ADD) ? r_rd : r_rn;
            end
            2'd1: begin
                w_ma = r_ld;
                w_mb = (r_op == REQ_ADD) ? r_rn : r_rd;
            end
            default: begin
                w_ma = r_ld;
                w_mb = r_rd;
            end
        endcase
    end

    ramc_gcd #(.N(N)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_st == S_LOAD && !(r_ph != PH_RES && r_y == '0)),
        .i_a     (r_x),
        .i_b     (r_y),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd)
    );

    ramc_div #(.N(N)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_st == S_DIVNS || r_st == S_DIVDS),
        .i_dividend ((r_st == S_DIVNS) ? r_x : r_y),
        .i_divisor  (r_g),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    ramc_mul #(.W(W), .N(N)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_st == S_MULS),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_m_axis_tready && r_st != S_DONE) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op <= t_req'(i_s_axis_tuser);
                        r_x  <= N'(i_s_axis_tdata[IW-1:0]);
                        r_y  <= N'(i_s_axis_tdata[FIELD_W+IW-1:FIELD_W]);
                        r_rn <= W'(i_s_axis_tdata[2*FIELD_W+IW-1:2*FIELD_W]);
                        r_rd <= W'(i_s_axis_tdata[3*FIELD_W+IW-1:3*FIELD_W]);
                        r_ph <= PH_LEFT;
                        r_st <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_ph != PH_RES && r_y == '0) begin
                        r_x  <= '0;
                        r_st <= S_NEXT;
                    end else begin
                        r_st <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (w_gcd_done) begin
                        r_g  <= w_gcd;
                        r_st <= S_DIVNS;
                    end
                end
                S_DIVNS: begin
                    r_st <= S_DIVN;
                end
                S_DIVN: begin
                    if (w_div_done) begin
                        r_x  <= w_quot;
                        r_st <= S_DIVDS;
                    end
                end
                S_DIVDS: begin
                    r_st <= S_DIVD;
                end
                S_DIVD: begin
                    if (w_div_done) begin
                        r_y  <= w_quot;
                        r_st <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    case (r_ph)
                        PH_LEFT: begin
                            r_ln <= r_x[W-1:0];
                            r_ld <= r_y[W-1:0];
                            r_x  <= N'(r_rn);
                            r_y  <= N'(r_rd);
                            r_ph <= PH_RIGHT;
                            r_st <= S_LOAD;
                        end
                        PH_RIGHT: begin
                            r_rn <= r_x[W-1:0];
                            r_rd <= r_y[W-1:0];
                            r_mi <= 2'd0;
                            r_st <= w_is_cmp ? S_DONE : S_MULS;
                        end
                        default: begin
                            r_st <= S_DONE;
                        end
                    endcase
                end
                S_MULS: begin
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        case (r_mi)
                            2'd0: begin
                                r_p0 <= w_prod;
                                r_mi <= 2'd1;
                                r_st <= S_MULS;
                            end
                            2'd1: begin
                                if (r_op == REQ_ADD) begin
                                    r_p1 <= w_prod;
                                    r_mi <= 2'd2;
                                    r_st <= S_MULS;
                                end else begin
                                    r_x  <= r_p0;
                                    r_y  <= w_prod;
                                    r_ph <= PH_RES;
                                    r_st <= S_LOAD;
                                end
                            end
                            default: begin
                                r_x  <= r_p0 + r_p1;
                                r_y  <= w_prod;
                                r_ph <= PH_RES;
                                r_st <= S_LOAD;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_ov || i_m_axis_tready) begin
                        r_ov <= 1'b1;
                        if (w_is_cmp) begin
                            r_onum <= '0;
                            r_oden <= '0;
                            r_oemp <= 1'b0;
                            r_oeq  <= w_same && !w_both;
                            r_one  <= !w_same && !w_both;
                        end else begin
                            r_onum <= RES_NUM_W'(r_x);
                            r_oden <= RES_DEN_W'(r_y);
                            r_oemp <= (r_x == '0) && (r_y == '0);
                            r_oeq  <= 1'b0;
                            r_one  <= 1'b0;
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_st == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_one, r_oeq, r_oemp, r_oden, r_onum};

endmodule

`default_nettype wire

@@ rtl/ramc_checker.sv @@
// ----------------------------------------------------------------------------
// ramc_checker
// Port-level checks for rational_add_mul_compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ramc_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_s_axis_tvalid,
    input wire logic                                o_s_axis_tready,
    input wire logic [ramc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input wire logic                                o_m_axis_tvalid,
    input wire logic                                i_m_axis_tready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second beat taken while one is in work");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[66] && o_m_axis_tdata[67]))
        else $error("equal and not-equal both set");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[66] || o_m_axis_tdata[67]) |->
            o_m_axis_tdata[65:0] == '0)
        else $error("compare result carries a fraction");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("outputs not idle after reset");

endmodule

bind rational_add_mul_compare ramc_checker u_ramc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

`default_nettype wire
